// ----- rtl/vlq_header_frame_receiver_core_macros.svh -----
// Assertion macros used by the checker of the frame receiver.
`ifndef VLQ_HEADER_FRAME_RECEIVER_CORE_MACROS_SVH
`define VLQ_HEADER_FRAME_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VLQH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VLQH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/vlqh_pkg.sv -----
package vlqh_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // LEB128 byte layout
  localparam int unsigned CONT_BIT   = 7;
  localparam int unsigned DATA_BITS  = 7;
  localparam int unsigned VALUE_BITS = 64;
  localparam logic [3:0]  LAST_GROUP = 4'd9;  // tenth byte of a value

  typedef enum logic [4:0] {
    PH_VERSION = 5'b00001,
    PH_TAG     = 5'b00010,
    PH_LENGTH  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_HALTED  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic                  has_result;
    logic [1:0]            kind;
    logic [VALUE_BITS-1:0] version;
    logic [VALUE_BITS-1:0] tag;
    logic [VALUE_BITS-1:0] payload_length;
    logic [7:0]            payload_byte;
    logic                  last;
  } parse_res_t;

endpackage

// ----- rtl/vlqh_in_if.sv -----
interface vlqh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- rtl/vlqh_out_if.sv -----
interface vlqh_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] version;
  logic [63:0] tag;
  logic [63:0] payload_length;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (output valid, output kind, output version, output tag,
                  output payload_length, output payload_byte, output last,
                  input ready);
  modport sink   (input valid, input kind, input version, input tag,
                  input payload_length, input payload_byte, input last,
                  output ready);
endinterface

// ----- rtl/vlqh_parse.sv -----
module vlqh_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          byte_in,
  output vlqh_pkg::parse_res_t res
);

  vlqh_pkg::phase_t phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  gc_r, gc_nxt;
  logic [63:0] ver_r, ver_nxt;
  logic [63:0] tag_r, tag_nxt;
  logic [63:0] rem_r, rem_nxt;

  logic [6:0]  data;
  logic        cont;
  logic [6:0]  shamt;
  logic [63:0] acc_or;
  logic [63:0] rem_dec;

  assign data    = byte_in[vlqh_pkg::DATA_BITS-1:0];
  assign cont    = byte_in[vlqh_pkg::CONT_BIT];
  // 7 * group count, at most 63
  assign shamt   = ({3'b000, gc_r} << 3) - {3'b000, gc_r};
  // bits pushed past bit 63 fall off
  assign acc_or  = acc_r | ({57'd0, data} << shamt);
  assign rem_dec = rem_r - 64'd1;

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    gc_nxt    = gc_r;
    ver_nxt   = ver_r;
    tag_nxt   = tag_r;
    rem_nxt   = rem_r;
    res       = '0;
    unique case (phase_r)
      vlqh_pkg::PH_PAYLOAD: begin
        res.has_result   = 1'b1;
        res.kind         = vlqh_pkg::KIND_PAYLOAD;
        res.payload_byte = byte_in;
        rem_nxt          = rem_dec;
        if (rem_dec == 64'd0) begin
          res.last  = 1'b1;
          phase_nxt = vlqh_pkg::PH_VERSION;
        end
      end
      vlqh_pkg::PH_VERSION, vlqh_pkg::PH_TAG, vlqh_pkg::PH_LENGTH: begin
        if (cont) begin
          if (gc_r == vlqh_pkg::LAST_GROUP) begin
            // overlong value: report and halt
            res.has_result = 1'b1;
            res.kind       = vlqh_pkg::KIND_ERROR;
            res.last       = 1'b1;
            phase_nxt      = vlqh_pkg::PH_HALTED;
            acc_nxt        = '0;
            gc_nxt         = '0;
          end else begin
            acc_nxt = acc_or;
            gc_nxt  = gc_r + 4'd1;
          end
        end else begin
          acc_nxt = '0;
          gc_nxt  = '0;
          if (phase_r == vlqh_pkg::PH_VERSION) begin
            ver_nxt   = acc_or;
            phase_nxt = vlqh_pkg::PH_TAG;
          end else if (phase_r == vlqh_pkg::PH_TAG) begin
            tag_nxt   = acc_or;
            phase_nxt = vlqh_pkg::PH_LENGTH;
          end else begin
            res.has_result     = 1'b1;
            res.kind           = vlqh_pkg::KIND_HEADER;
            res.version        = ver_r;
            res.tag            = tag_r;
            res.payload_length = acc_or;
            rem_nxt            = acc_or;
            if (acc_or == 64'd0) begin
              res.last  = 1'b1;
              phase_nxt = vlqh_pkg::PH_VERSION;
            end else begin
              phase_nxt = vlqh_pkg::PH_PAYLOAD;
            end
          end
        end
      end
      default: begin
        // halted: drop every byte
        phase_nxt = phase_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= vlqh_pkg::PH_VERSION;
      acc_r   <= '0;
      gc_r    <= '0;
      ver_r   <= '0;
      tag_r   <= '0;
      rem_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      gc_r    <= gc_nxt;
      ver_r   <= ver_nxt;
      tag_r   <= tag_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

// ----- rtl/vlq_header_frame_receiver_core.sv -----
// Path: an accepted byte waits in the input register; its result is loaded
//   into the result register on out_if, unless a full result register stalls it.
// Throughput: one byte per cycle unless stalled; the combinational parse update
//   is a shift-or and 64-bit decrement between the input and result registers.
// Reset: synchronous, rst_n low; returns to expecting a version value, clears
//   the accumulator and drops any item held in either register.
module vlq_header_frame_receiver_core (
  input  logic              clk,
  input  logic              rst_n,
  vlqh_in_if.sink           in_if,
  vlqh_out_if.source        out_if
);

  // Input register: one raw byte waiting for the parser.
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r;
  logic [63:0] out_version_r;
  logic [63:0] out_tag_r;
  logic [63:0] out_length_r;
  logic [7:0]  out_pbyte_r;
  logic        out_last_r;

  vlqh_pkg::parse_res_t res;
  logic                 advance;
  logic                 in_take;

  // Parser state lives in its own block; it steps only when the held byte
  // leaves the input register.
  vlqh_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .byte_in (s1_byte_r),
    .res     (res)
  );

  // Advance the held byte when it yields no item, or when the result register
  // is empty or being drained this cycle.
  assign advance = s1_valid_r && (!res.has_result || !out_valid_r || out_if.ready);

  // Take a new byte whenever the input register is free or moving on.
  assign in_if.ready = !s1_valid_r || advance;
  assign in_take     = in_if.valid && in_if.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && res.has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register: holds the byte until the parser takes it.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_if.in_byte;
    end
  end

  // Load a fresh item only when the parser emits one.
  always_ff @(posedge clk) begin
    if (advance && res.has_result) begin
      out_kind_r    <= res.kind;
      out_version_r <= res.version;
      out_tag_r     <= res.tag;
      out_length_r  <= res.payload_length;
      out_pbyte_r   <= res.payload_byte;
      out_last_r    <= res.last;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.kind           = out_kind_r;
  assign out_if.version        = out_version_r;
  assign out_if.tag            = out_tag_r;
  assign out_if.payload_length = out_length_r;
  assign out_if.payload_byte   = out_pbyte_r;
  assign out_if.last           = out_last_r;

endmodule

// ----- rtl/vlqh_checker.sv -----
`include "vlq_header_frame_receiver_core_macros.svh"

module vlqh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [63:0] out_version,
  input logic [63:0] out_tag,
  input logic [63:0] out_payload_length,
  input logic        out_last
);

  `VLQH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "stalled item dropped")
  `VLQH_ASSERT_NOW(a_err_last, out_valid && out_kind == vlqh_pkg::KIND_ERROR, out_last, "error item without last")
  `VLQH_ASSERT_NOW(a_hdr_last, out_valid && out_kind == vlqh_pkg::KIND_HEADER, out_last == (out_payload_length == 64'd0), "header last flag mismatch")
  `VLQH_ASSERT_NOW(a_pay_clean, out_valid && out_kind == vlqh_pkg::KIND_PAYLOAD, out_version == 64'd0 && out_tag == 64'd0 && out_payload_length == 64'd0, "payload item carries header fields")
  `VLQH_ASSERT_NEXT(a_halt, out_valid && out_ready && out_kind == vlqh_pkg::KIND_ERROR, !out_valid, "item after error")

endmodule

bind vlq_header_frame_receiver_core vlqh_checker u_vlqh_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .out_kind           (out_if.kind),
  .out_version        (out_if.version),
  .out_tag            (out_if.tag),
  .out_payload_length (out_if.payload_length),
  .out_last           (out_if.last)
);
